// ===== src/aes128_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_pkg: shared types, constants and round functions for the AES-128 core
// Holds the S-box tables (built at elaboration from GF(2^8) inversion), the
// register index codes and the byte-level round transforms.
// ----------------------------------------------------------------------------
package aes128_pkg;

   localparam int unsigned NUM_ROUNDS = 10;
   localparam int unsigned CNT_W      = 4;
   localparam logic [7:0]  GF_POLY    = 8'h1B;
   localparam logic [7:0]  RCON_FIRST = 8'h01;
   localparam logic [7:0]  RCON_LAST  = 8'h36;
   localparam logic [7:0]  AFFINE_C   = 8'h63;

   // register index codes of the configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd1;

   typedef logic [7:0]   byte_type;
   typedef logic [127:0] block_type;
   typedef byte_type     byte_table_type [256];

   function automatic byte_type gf_dbl(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type p;
      byte_type aa;
      p  = 8'h00;
      aa = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ aa;
         aa = gf_dbl(aa);
      end
      return p;
   endfunction

   // x^254 is the field inverse, zero maps to zero
   function automatic byte_type gf_inv(input byte_type x);
      byte_type r;
      byte_type b;
      logic [7:0] e;
      r = 8'h01;
      b = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gf_mul(r, b);
         b = gf_mul(b, b);
      end
      return r;
   endfunction

   function automatic byte_table_type build_sbox();
      byte_table_type t;
      byte_type b;
      for (int i = 0; i < 256; i++) begin
         b = gf_inv(i[7:0]);
         t[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
              ^ {b[3:0], b[7:4]} ^ AFFINE_C;
      end
      return t;
   endfunction

   function automatic byte_table_type build_sbox_rev();
      byte_table_type fwd;
      byte_table_type t;
      fwd = build_sbox();
      for (int i = 0; i < 256; i++) begin
         t[fwd[i]] = i[7:0];
      end
      return t;
   endfunction

   localparam byte_table_type SBOX     = build_sbox();
   localparam byte_table_type SBOX_REV = build_sbox_rev();

   // byte n of a block: byte 0 is the most significant
   function automatic byte_type get_byte(input block_type s, input int n);
      return s[127 - 8 * n -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // next round key from the previous one
   function automatic block_type next_round_key(input block_type k, input byte_type rc);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic block_type sub_bytes(input block_type s, input logic inv);
      block_type o;
      for (int n = 0; n < 16; n++) begin
         o[127 - 8 * n -: 8] = inv ? SBOX_REV[get_byte(s, n)] : SBOX[get_byte(s, n)];
      end
      return o;
   endfunction

   // byte n sits at row n%4, column n/4
   function automatic block_type shift_rows(input block_type s, input logic inv);
      block_type o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv) o[127 - 8 * (4 * c + r) -: 8] = get_byte(s, 4 * ((c - r + 4) % 4) + r);
            else     o[127 - 8 * (4 * c + r) -: 8] = get_byte(s, 4 * ((c + r) % 4) + r);
         end
      end
      return o;
   endfunction

   function automatic block_type mix_columns(input block_type s, input logic inv);
      block_type o;
      byte_type a [4];
      byte_type x2 [4];
      byte_type x4 [4];
      byte_type x8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = get_byte(s, 4 * c + r);
            x2[r] = gf_dbl(a[r]);
            x4[r] = gf_dbl(x2[r]);
            x8[r] = gf_dbl(x4[r]);
         end
         for (int r = 0; r < 4; r++) begin
            if (inv) begin
               o[127 - 8 * (4 * c + r) -: 8] =
                  (x8[r] ^ x4[r] ^ x2[r])
                  ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                  ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
                  ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
            end else begin
               o[127 - 8 * (4 * c + r) -: 8] =
                  x2[r] ^ (x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                  ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
            end
         end
      end
      return o;
   endfunction

   // one pipeline round: forward SB,SR,MC,ARK or inverse ISR,ISB,ARK,IMC; the last round skips MC/IMC
   function automatic block_type cipher_round(input block_type s, input block_type rk_enc,
                                              input block_type rk_dec, input logic dec,
                                              input logic last);
      block_type t;
      if (dec) begin
         t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ rk_dec;
         if (!last) t = mix_columns(t, 1'b1);
      end else begin
         t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
         if (!last) t = mix_columns(t, 1'b0);
         t = t ^ rk_enc;
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== src/aes128_block_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes128_block_cipher: pipelined AES-128 ECB encrypt/decrypt core
// Eleven register stages (initial key add plus ten rounds) with a round-key
// schedule rebuilt iteratively after reset and after each key write.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  request   req_valid req_stall req_mode req_block_*  in (stall out)
//  response  rsp_valid rsp_stall rsp_result_*          out (stall in)
//  config    csr_write csr_index csr_data              in
//
// One request enters per cycle while req_stall is low; each result reaches the response ports
// through the entry register and the ten round stages behind it.
// After reset and after each key write the schedule unit rebuilds the round keys,
// one round key per cycle; req_stall is high while the rebuild runs.
// A stalled response holds the last stage; earlier stages keep filling bubbles.
module aes128_block_cipher (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_mode,
   input  wire logic [63:0]                            req_block_high,
   input  wire logic [63:0]                            req_block_low,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [63:0]                                 rsp_result_high,
   output logic [63:0]                                 rsp_result_low,
   input  wire logic                                   csr_write,
   input  wire logic [aes128_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [63:0]                            csr_data
);

   localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

   // key schedule state
   aes128_pkg::block_type                  key_ff, key_in;
   aes128_pkg::block_type                  last_ff;
   aes128_pkg::block_type                  rk_ff [1:NR];
   aes128_pkg::byte_type                   rcon_ff;
   logic [aes128_pkg::CNT_W-1:0]           cnt_ff;
   logic                                   busy_ff;
   logic                                   key_wr;
   aes128_pkg::block_type                  rk_next;
   aes128_pkg::block_type                  round_key [0:NR];

   // pipeline state
   aes128_pkg::block_type                  state_ff [0:NR];
   logic                                   mode_ff  [0:NR];
   logic                                   valid_ff [0:NR];
   logic                                   adv      [0:NR];
   aes128_pkg::block_type                  round_out [1:NR];
   logic                                   req_take;

   // decode key writes
   always_comb begin
      key_in = key_ff;
      key_wr = 1'b0;
      case (csr_index)
         aes128_pkg::CSR_KEY_HIGH: begin
            key_in = {csr_data, key_ff[63:0]};
            key_wr = csr_write;
         end
         aes128_pkg::CSR_KEY_LOW: begin
            key_in = {key_ff[127:64], csr_data};
            key_wr = csr_write;
         end
         default: begin
            key_in = key_ff;
            key_wr = 1'b0;
         end
      endcase
   end

   assign rk_next = aes128_pkg::next_round_key(last_ff, rcon_ff);

   // rebuild one round key per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         last_ff <= '0;
         rcon_ff <= aes128_pkg::RCON_FIRST;
         cnt_ff  <= aes128_pkg::CNT_W'(1);
         busy_ff <= 1'b1;
      end else if (key_wr) begin
         key_ff  <= key_in;
         last_ff <= key_in;
         rcon_ff <= aes128_pkg::RCON_FIRST;
         cnt_ff  <= aes128_pkg::CNT_W'(1);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         last_ff <= rk_next;
         rcon_ff <= aes128_pkg::gf_dbl(rcon_ff);
         if (cnt_ff == aes128_pkg::CNT_W'(NR)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + aes128_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NR; i++) begin
         if (busy_ff && !key_wr && !reset && cnt_ff == aes128_pkg::CNT_W'(i)) begin
            rk_ff[i] <= rk_next;
         end
      end
   end

   always_comb begin
      round_key[0] = key_ff;
      for (int i = 1; i <= NR; i++) begin
         round_key[i] = rk_ff[i];
      end
   end

   // advance a stage when it is empty or the next one moves
   always_comb begin
      adv[NR] = !valid_ff[NR] || !rsp_stall;
      for (int i = NR - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i + 1];
      end
   end

   assign req_stall = busy_ff || !adv[0];
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      for (int i = 1; i <= NR; i++) begin
         round_out[i] = aes128_pkg::cipher_round(state_ff[i - 1], round_key[i],
                                                 round_key[NR - i], mode_ff[i - 1],
                                                 i == NR);
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NR; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (adv[0]) valid_ff[0] <= req_take;
         for (int i = 1; i <= NR; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i - 1];
         end
      end
   end

   // stage payloads: initial key add, then one round per stage
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         state_ff[0] <= {req_block_high, req_block_low}
                        ^ (req_mode ? round_key[NR] : round_key[0]);
         mode_ff[0]  <= req_mode;
      end
      for (int i = 1; i <= NR; i++) begin
         if (adv[i]) begin
            state_ff[i] <= round_out[i];
            mode_ff[i]  <= mode_ff[i - 1];
         end
      end
   end

   assign rsp_valid       = valid_ff[NR];
   assign rsp_result_high = state_ff[NR][127:64];
   assign rsp_result_low  = state_ff[NR][63:0];

   // no request enters while the schedule is rebuilt
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_take)
      else $error("request taken during key schedule rebuild");

   // rebuild counter stays within the round range
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && (cnt_ff <= aes128_pkg::CNT_W'(NR)))
      else $error("key schedule counter out of range");

   // a key write always starts a rebuild
   a_write_rebuild: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> busy_ff && (cnt_ff == aes128_pkg::CNT_W'(1)))
      else $error("key write did not restart the schedule");

   // the last rebuild step uses the final round constant
   a_rcon_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !key_wr && cnt_ff == aes128_pkg::CNT_W'(NR))
         |-> rcon_ff == aes128_pkg::RCON_LAST)
      else $error("round constant out of step");

endmodule
`default_nettype wire
